// ===== sv/eot_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the CORDIC angle table of the odometry tracker.
// No dependencies.
package eot_pkg;

	localparam int STEP_W = 5;
	localparam int TAB_LEN = 24;

	localparam logic [1:0] KIND_RIGHT = 2'd0;
	localparam logic [1:0] KIND_LEFT  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;
	localparam logic [1:0] KIND_RSVD  = 2'd3;

	localparam logic [1:0] REG_RIGHT_SCALE = 2'd0;
	localparam logic [1:0] REG_LEFT_SCALE  = 2'd1;
	localparam logic [1:0] REG_PERIOD      = 2'd2;
	localparam logic [1:0] REG_RSVD        = 2'd3;

	localparam logic [3:0] OP_NONE  = 4'd0;
	localparam logic [3:0] OP_IDLE  = 4'd1;
	localparam logic [3:0] OP_MUL_R = 4'd2;
	localparam logic [3:0] OP_MUL_L = 4'd3;
	localparam logic [3:0] OP_PREP  = 4'd4;
	localparam logic [3:0] OP_ITER  = 4'd5;
	localparam logic [3:0] OP_MHI   = 4'd6;
	localparam logic [3:0] OP_MLO   = 4'd7;
	localparam logic [3:0] OP_SUM   = 4'd8;
	localparam logic [3:0] OP_UPD   = 4'd9;
	localparam logic [3:0] OP_OUT   = 4'd10;

	localparam logic signed [27:0] FULL_TURN    = 28'sd23592960;
	localparam logic signed [27:0] HALF_TURN    = 28'sd11796480;
	localparam logic signed [27:0] QUARTER_TURN = 28'sd5898240;
	localparam logic signed [31:0] GAIN_Q28     = 32'sd163008219;

	typedef struct packed {
		logic [3:0]        op;
		logic              accept;
		logic              sel_y;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic upd_due;
	} sts_t;

	function automatic logic [21:0] atan_tab(input logic [STEP_W-1:0] i);
		logic [21:0] v;
		case (i)
			5'd0: v = 22'd2949120;
			5'd1: v = 22'd1740967;
			5'd2: v = 22'd919879;
			5'd3: v = 22'd466945;
			5'd4: v = 22'd234379;
			5'd5: v = 22'd117304;
			5'd6: v = 22'd58666;
			5'd7: v = 22'd29335;
			5'd8: v = 22'd14668;
			5'd9: v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/eot_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the odometry tracker.
// Depends on eot_pkg.
module eot_ctrl #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  eot_pkg::sts_t sts,
	output eot_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL_R = 4'd1;
	localparam logic [3:0] ST_MUL_L = 4'd2;
	localparam logic [3:0] ST_PREP  = 4'd3;
	localparam logic [3:0] ST_ITER  = 4'd4;
	localparam logic [3:0] ST_MHI_X = 4'd5;
	localparam logic [3:0] ST_MLO_X = 4'd6;
	localparam logic [3:0] ST_SUM_X = 4'd7;
	localparam logic [3:0] ST_UPD_X = 4'd8;
	localparam logic [3:0] ST_MHI_Y = 4'd9;
	localparam logic [3:0] ST_MLO_Y = 4'd10;
	localparam logic [3:0] ST_SUM_Y = 4'd11;
	localparam logic [3:0] ST_UPD_Y = 4'd12;
	localparam logic [3:0] ST_OUT   = 4'd13;

	localparam logic [eot_pkg::STEP_W-1:0] LAST_STEP = eot_pkg::STEP_W'(CORDIC_STEPS - 1);

	logic [3:0]                   state_q, state_d;
	logic [eot_pkg::STEP_W-1:0]   step_q;
	logic                         mvalid_q;
	logic                         out_ok;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;
	assign out_ok   = !mvalid_q || m_tready;

	always_comb begin
		state_d    = state_q;
		cmd.op     = eot_pkg::OP_NONE;
		cmd.accept = 1'b0;
		cmd.sel_y  = 1'b0;
		cmd.step   = step_q;
		case (state_q)
			ST_IDLE: begin
				cmd.op     = eot_pkg::OP_IDLE;
				cmd.accept = s_tvalid;
				if (s_tvalid && sts.upd_due) state_d = ST_MUL_R;
			end
			ST_MUL_R: begin cmd.op = eot_pkg::OP_MUL_R; state_d = ST_MUL_L; end
			ST_MUL_L: begin cmd.op = eot_pkg::OP_MUL_L; state_d = ST_PREP; end
			ST_PREP:  begin cmd.op = eot_pkg::OP_PREP;  state_d = ST_ITER; end
			ST_ITER: begin
				cmd.op = eot_pkg::OP_ITER;
				if (step_q == LAST_STEP) state_d = ST_MHI_X;
			end
			ST_MHI_X: begin cmd.op = eot_pkg::OP_MHI; state_d = ST_MLO_X; end
			ST_MLO_X: begin cmd.op = eot_pkg::OP_MLO; state_d = ST_SUM_X; end
			ST_SUM_X: begin cmd.op = eot_pkg::OP_SUM; state_d = ST_UPD_X; end
			ST_UPD_X: begin cmd.op = eot_pkg::OP_UPD; state_d = ST_MHI_Y; end
			ST_MHI_Y: begin
				cmd.op = eot_pkg::OP_MHI; cmd.sel_y = 1'b1; state_d = ST_MLO_Y;
			end
			ST_MLO_Y: begin
				cmd.op = eot_pkg::OP_MLO; cmd.sel_y = 1'b1; state_d = ST_SUM_Y;
			end
			ST_SUM_Y: begin
				cmd.op = eot_pkg::OP_SUM; cmd.sel_y = 1'b1; state_d = ST_UPD_Y;
			end
			ST_UPD_Y: begin
				cmd.op = eot_pkg::OP_UPD; cmd.sel_y = 1'b1; state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ok) begin
					cmd.op  = eot_pkg::OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PREP) step_q <= '0;
			else if (state_q == ST_ITER) step_q <= step_q + 1'b1;
			if (cmd.op == eot_pkg::OP_OUT) mvalid_q <= 1'b1;
			else if (m_tready) mvalid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/eot_dp.sv =====
`timescale 1ns / 1ps
// Datapath: encoder counters, shared multiplier, CORDIC atan and sin/cos, pose accumulators.
// Depends on eot_pkg.
module eot_dp #(
	parameter int WHEEL_TRACK_MM = 200
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [17:0]   cfg_data,
	input  logic [1:0]    kind,
	input  logic          phase_b,
	input  eot_pkg::cmd_t cmd,
	output eot_pkg::sts_t sts,
	output logic [89:0]   result
);

	localparam logic signed [39:0] TRACK_Q16 = 40'(WHEEL_TRACK_MM) <<< 16;

	logic [17:0]        rs_q, ls_q;
	logic [9:0]         per_q, tick_q, tick_nxt;
	logic signed [15:0] rc_q, lc_q;
	logic signed [31:0] x_q, y_q;
	logic signed [25:0] h_q;
	logic signed [50:0] prod_q, prod;
	logic signed [18:0] ma;
	logic signed [31:0] mb, cs;
	logic signed [33:0] dr_q, dl;
	logic signed [34:0] r_q;
	logic signed [36:0] e;
	logic signed [39:0] vx_q, vy_q;
	logic signed [27:0] z_q, a_q, hn, fa;
	logic signed [26:0] hn_q;
	logic               zero_q, neg_q, fneg;
	logic signed [31:0] cx_q, cy_q;
	logic signed [65:0] acc_q;
	logic signed [37:0] dpos;
	logic signed [39:0] psum;
	logic signed [31:0] psat;
	logic signed [27:0] tab, hh, hw;
	logic [89:0]        out_q;

	assign tick_nxt    = tick_q + 10'd1;
	assign sts.upd_due = (kind == eot_pkg::KIND_TICK) && (tick_nxt >= per_q);
	assign result      = out_q;
	assign tab         = 28'($signed({1'b0, eot_pkg::atan_tab(cmd.step)}));

	always_comb begin
		cs = cmd.sel_y ? cy_q : cx_q;
		if (neg_q) cs = -cs;
		case (cmd.op)
			eot_pkg::OP_MUL_R: begin ma = 19'(rc_q); mb = 32'($signed({1'b0, rs_q})); end
			eot_pkg::OP_MUL_L: begin ma = 19'(lc_q); mb = 32'($signed({1'b0, ls_q})); end
			eot_pkg::OP_MHI:   begin ma = 19'($signed(r_q[34:18])); mb = cs; end
			default:           begin ma = $signed({1'b0, r_q[17:0]}); mb = cs; end
		endcase
		prod = ma * mb;
	end

	always_comb begin
		dl  = prod_q[33:0];
		e   = (37'(dl) - 37'(dr_q)) <<< 1;
		hn  = (h_q < 0) ? 28'(h_q) + eot_pkg::FULL_TURN : 28'(h_q);
		fa  = (hn > eot_pkg::HALF_TURN) ? hn - eot_pkg::FULL_TURN : hn;
		fneg = 1'b0;
		if (fa > eot_pkg::QUARTER_TURN) begin
			fa = fa - eot_pkg::HALF_TURN; fneg = 1'b1;
		end else if (fa < -eot_pkg::QUARTER_TURN) begin
			fa = fa + eot_pkg::HALF_TURN; fneg = 1'b1;
		end
		dpos = 38'(acc_q >>> 28);
		psum = (cmd.sel_y ? 40'(y_q) : 40'(x_q)) + 40'(dpos);
		if (psum > 40'sd2147483647) psat = 32'sh7fffffff;
		else if (psum < -40'sd2147483648) psat = 32'sh80000000;
		else psat = psum[31:0];
		hh = 28'(hn_q) - z_q;
		if (hh > eot_pkg::FULL_TURN) hw = hh - eot_pkg::FULL_TURN;
		else if (hh < -eot_pkg::FULL_TURN) hw = hh + eot_pkg::FULL_TURN;
		else hw = hh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q   <= 18'd65536;
			ls_q   <= 18'd65536;
			per_q  <= 10'd50;
			tick_q <= '0;
			rc_q   <= '0;
			lc_q   <= '0;
			x_q    <= '0;
			y_q    <= '0;
			h_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					eot_pkg::REG_RIGHT_SCALE: rs_q  <= cfg_data;
					eot_pkg::REG_LEFT_SCALE:  ls_q  <= cfg_data;
					eot_pkg::REG_PERIOD:      per_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				case (kind)
					eot_pkg::KIND_RIGHT: begin
						if (phase_b) begin
							if (rc_q != 16'sh7fff) rc_q <= rc_q + 16'sd1;
						end else if (rc_q != 16'sh8000) rc_q <= rc_q - 16'sd1;
					end
					eot_pkg::KIND_LEFT: begin
						if (!phase_b) begin
							if (lc_q != 16'sh7fff) lc_q <= lc_q + 16'sd1;
						end else if (lc_q != 16'sh8000) lc_q <= lc_q - 16'sd1;
					end
					eot_pkg::KIND_TICK: tick_q <= sts.upd_due ? 10'd0 : tick_nxt;
					default: ;
				endcase
			end
			if (cmd.op == eot_pkg::OP_UPD) begin
				if (cmd.sel_y) y_q <= psat;
				else x_q <= psat;
			end
			if (cmd.op == eot_pkg::OP_OUT) begin
				h_q  <= hw[25:0];
				rc_q <= '0;
				lc_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			eot_pkg::OP_MUL_R: prod_q <= prod;
			eot_pkg::OP_MUL_L: begin
				dr_q   <= prod_q[33:0];
				prod_q <= prod;
			end
			eot_pkg::OP_PREP: begin
				r_q    <= 35'(dr_q) + 35'(dl);
				vx_q   <= TRACK_Q16;
				vy_q   <= 40'(e);
				z_q    <= '0;
				zero_q <= (e == '0);
				hn_q   <= hn[26:0];
				a_q    <= fa;
				neg_q  <= fneg;
				cx_q   <= eot_pkg::GAIN_Q28;
				cy_q   <= '0;
			end
			eot_pkg::OP_ITER: begin
				if (!zero_q) begin
					if (vy_q >= 0) begin
						vx_q <= vx_q + (vy_q >>> cmd.step);
						vy_q <= vy_q - (vx_q >>> cmd.step);
						z_q  <= z_q + tab;
					end else begin
						vx_q <= vx_q - (vy_q >>> cmd.step);
						vy_q <= vy_q + (vx_q >>> cmd.step);
						z_q  <= z_q - tab;
					end
				end
				if (a_q >= 0) begin
					cx_q <= cx_q - (cy_q >>> cmd.step);
					cy_q <= cy_q + (cx_q >>> cmd.step);
					a_q  <= a_q - tab;
				end else begin
					cx_q <= cx_q + (cy_q >>> cmd.step);
					cy_q <= cy_q - (cx_q >>> cmd.step);
					a_q  <= a_q + tab;
				end
			end
			eot_pkg::OP_MHI: prod_q <= prod;
			eot_pkg::OP_MLO: begin
				acc_q  <= 66'(prod_q) <<< 18;
				prod_q <= prod;
			end
			eot_pkg::OP_SUM: acc_q <= acc_q + 66'(prod_q) + 66'sd134217728;
			eot_pkg::OP_OUT: out_q <= {hw[25:0], y_q, x_q};
			default: ;
		endcase
	end

endmodule

// ===== sv/encoder_odometry_tracker_core.sv =====
`timescale 1ns / 1ps
// Encoder and tick items are taken whenever no update is running; each is applied as it is taken.
// A tick that ends a period starts an update: two count multiplies, the shared CORDIC loop,
// then high product, low product, sum and update per axis on one 19x32 multiplier.
// Next item taken the cycle after the result is registered; a pending result stalls only the
// end of the following update. Reset clears counts, pose and registers to their defaults.
module encoder_odometry_tracker_core #(
	parameter int WHEEL_TRACK_MM = 200,
	parameter int CORDIC_STEPS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [17:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] phase_b
	input  logic [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata    // [31:0] pos_x, [63:32] pos_y, [89:64] heading
);

	eot_pkg::cmd_t cmd;
	eot_pkg::sts_t sts;
	logic [89:0]   result;

	eot_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.sts(sts), .cmd(cmd)
	);

	eot_dp #(.WHEEL_TRACK_MM(WHEEL_TRACK_MM)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.kind(s_tuser), .phase_b(s_tdata[0]),
		.cmd(cmd), .sts(sts), .result(result)
	);

	assign m_tdata = {6'd0, result};

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (cmd.op == eot_pkg::OP_IDLE))
		else $error("input taken outside idle");

	a_rise_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.op == eot_pkg::OP_OUT))
		else $error("result valid without load");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[89:64]) <= 26'sd23592960 &&
			$signed(m_tdata[89:64]) >= -26'sd23592960))
		else $error("heading out of range");

endmodule
